### hw/rtl/ttcs_pkg.sv
// ----------------------------------------------------------------------------
// ttcs_pkg
// Shared types and constants for the text terminal cursor and scroll block.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcs_pkg;

   localparam int COLUMNS_DEFAULT = 40;
   localparam int ROWS_DEFAULT    = 25;

   localparam logic [7:0] CODE_CR    = 8'd13;
   localparam logic [7:0] CODE_LF    = 8'd10;
   localparam logic [7:0] CODE_BS    = 8'd8;
   localparam logic [7:0] CODE_SPACE = 8'h20;

   typedef enum logic [1:0] {
      REQ_PUT   = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   char_code;
      logic [4:0]   read_row;
      logic [5:0]   read_col;
   } req_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [5:0] cursor_col;
      logic [4:0] cursor_row;
      logic       did_scroll;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FILL,
      ST_READ_WAIT,
      ST_RESPOND
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic put;
      logic clear;
      logic rd_issue;
      logic rd_capture;
      logic rd_blank;
      logic fill_step;
      logic respond;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      req_kind_type kind;
      logic         glyph;
      logic         row_valid;
      logic         rd_ok;
      logic         rd_row_valid;
      logic         fill_last;
      logic         rsp_free;
   } status_type;

endpackage

`default_nettype wire

### hw/rtl/text_terminal_cursor_scroll.sv
// Each item is decoded, then its result is registered once the result slot is free;
// a read of a row written since it was last blanked first waits on the RAM read data.
// A character put into a row still blank since reset, clear or scroll first sweeps
// that row with spaces through the single RAM port before the character is written.
// One item at a time: a new item is taken only once the last result is registered.
// Reset: synchronous; all rows read as spaces and the cursor is home at once,
// with no clearing pass over the cell memory.
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// Character-cell terminal with cursor, backspace, newline, scroll and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cursor_scroll
   import ttcs_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   cmd_type    cmd;
   status_type status;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   // Sequencer: idle, decode, row sweep, read wait, hand-off of the result item
   ttcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Cursor, row rebase for scrolling, per-row valid bits, result register.
   // Scrolling only advances the rebase offset and marks the new bottom row blank.
   ttcs_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .ram_we      (ram_we),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .ram_rdata   (ram_rdata)
   );

   // Screen cells, row-major by physical row
   ttcs_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

### hw/rtl/ttcs_ram.sv
// ----------------------------------------------------------------------------
// ttcs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1000
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hw/rtl/ttcs_ctrl.sv
// ----------------------------------------------------------------------------
// ttcs_ctrl
// Sequencer: accepts one item, steps the datapath through it, hands off result.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcs_ctrl
   import ttcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.kind)
               REQ_PUT: begin
                  if (status.glyph && !status.row_valid) begin
                     // blank the row before its first character lands
                     state_in = ST_FILL;
                  end else begin
                     cmd.put  = 1'b1;
                     state_in = ST_RESPOND;
                  end
               end
               REQ_READ: begin
                  if (!status.rd_ok) begin
                     state_in = ST_RESPOND;
                  end else if (!status.rd_row_valid) begin
                     cmd.rd_blank = 1'b1;
                     state_in     = ST_RESPOND;
                  end else begin
                     cmd.rd_issue = 1'b1;
                     state_in     = ST_READ_WAIT;
                  end
               end
               REQ_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_RESPOND;
               end
               default: begin
                  state_in = ST_RESPOND;
               end
            endcase
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_DECODE;
            end
         end
         ST_READ_WAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (status.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/ttcs_dp.sv
// ----------------------------------------------------------------------------
// ttcs_dp
// Datapath: cursor, row rebase, row valid bits, row fill sweep, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcs_dp
   import ttcs_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT,
   localparam int CW     = $clog2(COLUMNS),
   localparam int RW     = $clog2(ROWS),
   localparam int AW     = $clog2(ROWS * COLUMNS)
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   output status_type      status,
   input  wire req_type    req_payload,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_payload,
   output logic            ram_we,
   output logic [AW-1:0]   ram_addr,
   output logic [7:0]      ram_wdata,
   input  wire logic [7:0] ram_rdata
);

   logic [CW-1:0]   cur_col_ff, cur_col_in;
   logic [RW-1:0]   cur_row_ff, cur_row_in;
   logic [RW-1:0]   base_ff, base_in;
   logic [ROWS-1:0] row_valid_ff, row_valid_in;
   logic [CW-1:0]   sweep_ff, sweep_in;
   logic            rsp_valid_ff, rsp_valid_in;
   req_type         req_ff, req_in;
   rsp_type         rsp_ff, rsp_in;
   logic [7:0]      cell_ff, cell_in;
   logic            scroll_ff, scroll_in;

   logic [RW:0]   sum_cur, sum_rd;
   logic [RW-1:0] phys_cur, phys_rd, rd_row;
   logic [CW-1:0] rd_col, put_col;
   logic          is_nl, is_bs, rd_ok, col_last, row_last, nl_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         base_ff      <= '0;
         row_valid_ff <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         base_ff      <= base_in;
         row_valid_ff <= row_valid_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      cell_ff   <= cell_in;
      scroll_ff <= scroll_in;
   end

   always_comb begin
      // logical row to physical row through the rebase offset
      sum_cur  = {1'b0, cur_row_ff} + {1'b0, base_ff};
      phys_cur = (sum_cur >= (RW+1)'(ROWS)) ? RW'(sum_cur - (RW+1)'(ROWS)) : RW'(sum_cur);
      rd_row   = RW'(req_ff.read_row);
      rd_col   = CW'(req_ff.read_col);
      sum_rd   = {1'b0, rd_row} + {1'b0, base_ff};
      phys_rd  = (sum_rd >= (RW+1)'(ROWS)) ? RW'(sum_rd - (RW+1)'(ROWS)) : RW'(sum_rd);
      rd_ok    = (7'(req_ff.read_row) < 7'(ROWS)) && (8'(req_ff.read_col) < 8'(COLUMNS));
      is_nl    = (req_ff.char_code == CODE_CR) || (req_ff.char_code == CODE_LF);
      is_bs    = (req_ff.char_code == CODE_BS);
      col_last = (cur_col_ff == CW'(COLUMNS - 1));
      row_last = (cur_row_ff == RW'(ROWS - 1));
      put_col  = is_bs ? (cur_col_ff - CW'(1)) : cur_col_ff;

      status.kind         = req_ff.req_type;
      status.glyph        = !is_nl && !is_bs;
      status.row_valid    = row_valid_ff[phys_cur];
      status.rd_ok        = rd_ok;
      status.rd_row_valid = row_valid_ff[phys_rd];
      status.fill_last    = (sweep_ff == CW'(COLUMNS - 1));
      status.rsp_free     = !rsp_valid_ff || rsp_ready;

      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      base_in      = base_ff;
      row_valid_in = row_valid_ff;
      sweep_in     = sweep_ff;
      req_in       = req_ff;
      cell_in      = cell_ff;
      scroll_in    = scroll_ff;
      nl_go        = 1'b0;

      if (cmd.load) begin
         req_in    = req_payload;
         cell_in   = '0;
         scroll_in = 1'b0;
      end

      if (cmd.clear) begin
         row_valid_in = '0;
         cur_col_in   = '0;
         cur_row_in   = '0;
      end

      if (cmd.rd_blank) begin
         cell_in = CODE_SPACE;
      end
      if (cmd.rd_capture) begin
         cell_in = ram_rdata;
      end

      if (cmd.fill_step) begin
         if (status.fill_last) begin
            sweep_in               = '0;
            row_valid_in[phys_cur] = 1'b1;
         end else begin
            sweep_in = sweep_ff + CW'(1);
         end
      end

      if (cmd.put) begin
         if (is_nl) begin
            nl_go = 1'b1;
         end else if (is_bs) begin
            if (cur_col_ff != '0) begin
               cur_col_in = cur_col_ff - CW'(1);
            end
         end else if (col_last) begin
            nl_go = 1'b1;
         end else begin
            cur_col_in = cur_col_ff + CW'(1);
         end
      end

      if (nl_go) begin
         cur_col_in = '0;
         if (row_last) begin
            // scroll: old top row becomes the blank bottom row
            base_in               = (base_ff == RW'(ROWS - 1)) ? '0 : base_ff + RW'(1);
            row_valid_in[base_ff] = 1'b0;
            scroll_in             = 1'b1;
         end else begin
            cur_row_in = cur_row_ff + RW'(1);
         end
      end

      ram_we    = cmd.fill_step
                  || (cmd.put && status.glyph)
                  || (cmd.put && is_bs && (cur_col_ff != '0) && status.row_valid);
      ram_wdata = (cmd.fill_step || is_bs) ? CODE_SPACE : req_ff.char_code;
      if (cmd.fill_step) begin
         ram_addr = AW'(phys_cur) * AW'(COLUMNS) + AW'(sweep_ff);
      end else if (cmd.rd_issue) begin
         ram_addr = AW'(phys_rd) * AW'(COLUMNS) + AW'(rd_col);
      end else begin
         ram_addr = AW'(phys_cur) * AW'(COLUMNS) + AW'(put_col);
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.respond) begin
         rsp_valid_in      = 1'b1;
         rsp_in.cell_char  = cell_ff;
         rsp_in.cursor_col = 6'(cur_col_ff);
         rsp_in.cursor_row = 5'(cur_row_ff);
         rsp_in.did_scroll = scroll_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/ttcs_chk.sv
// ----------------------------------------------------------------------------
// ttcs_chk
// Port-level checks on the terminal block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcs_chk
   import ttcs_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   // one item in flight: no acceptance straight after another
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in flight");

   // the cursor stays on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.cursor_col < COLUMNS) && (rsp_payload.cursor_row < ROWS))
      else $error("cursor outside the screen");

   // a scroll leaves the cursor at the start of the bottom row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.did_scroll
      |-> (rsp_payload.cursor_col == 0) && (rsp_payload.cursor_row == 5'(ROWS - 1)))
      else $error("scroll without cursor at bottom row start");

endmodule

bind text_terminal_cursor_scroll ttcs_chk #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_ttcs_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text terminal cursor and scroll block.
// A shadow screen and cursor predict each result that is not typed in by hand. A short
// probe table runs first, then weighted random terminal traffic, with random idling on
// both channels.
// ----------------------------------------------------------------------------

module tb;
   import ttcs_pkg::*;

   localparam int SCREEN_COLS    = COLUMNS_DEFAULT;
   localparam int SCREEN_ROWS    = ROWS_DEFAULT;
   localparam int PROBE_COUNT    = 23;
   localparam int RANDOM_ITEMS   = 1050;
   localparam int DRAIN_INTERVAL = 250;
   localparam int CALM_FIRST     = 300;
   localparam int CALM_LAST      = 499;
   localparam int IDLE_PERCENT   = 17;
   localparam int RESET_CYCLES   = 12;
   localparam int TAIL_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT = 2000;

   // One probe: the item, and the result typed in by hand where it is obvious.
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type answer;
   } probe_row_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Shadow copy of the terminal: every cell plus the cursor.
   logic [7:0] shadow_screen [SCREEN_ROWS][SCREEN_COLS];
   logic [5:0] shadow_col;
   logic [4:0] shadow_row;

   rsp_type       expected_rsps [$];
   probe_row_type probe_table [PROBE_COUNT];
   logic          typed_pending  = 1'b0;
   rsp_type       typed_answer   = '0;
   logic          calm_stretch   = 1'b0;
   int unsigned   mismatch_count = 0;
   int unsigned   idle_cycles    = 0;

   text_terminal_cursor_scroll dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow terminal
   // ------------------------------------------------------------------------

   // Fill the whole screen with spaces and home the cursor.
   task automatic blank_shadow();
      int r;
      int c;
      for (r = 0; r < SCREEN_ROWS; r++)
         for (c = 0; c < SCREEN_COLS; c++)
            shadow_screen[r][c] = CODE_SPACE;
      shadow_col = '0;
      shadow_row = '0;
   endtask

   // Go to column 0 of the next row; from the bottom row, scroll up instead.
   task automatic start_new_line(output logic scrolled);
      int r;
      int c;
      scrolled   = 1'b0;
      shadow_col = '0;
      if (shadow_row == 5'(SCREEN_ROWS - 1)) begin
         // shift every row up by one, blank the bottom row, stay on it
         for (r = 0; r < SCREEN_ROWS - 1; r++)
            for (c = 0; c < SCREEN_COLS; c++)
               shadow_screen[r][c] = shadow_screen[r + 1][c];
         for (c = 0; c < SCREEN_COLS; c++)
            shadow_screen[SCREEN_ROWS - 1][c] = CODE_SPACE;
         scrolled = 1'b1;
      end else begin
         shadow_row = shadow_row + 5'd1;
      end
   endtask

   // Apply one accepted item to the shadow terminal and work out its result.
   task automatic advance_terminal(input req_type item, output rsp_type outcome);
      logic scrolled;
      outcome  = '0;
      scrolled = 1'b0;
      case (item.req_type)
         REQ_PUT: begin
            case (item.char_code)
               CODE_CR, CODE_LF: start_new_line(scrolled);
               CODE_BS: begin
                  // backspace does nothing in column 0
                  if (shadow_col != '0) begin
                     shadow_col = shadow_col - 6'd1;
                     shadow_screen[shadow_row][shadow_col] = CODE_SPACE;
                  end
               end
               default: begin
                  // any other code, control bytes included, is stored as is
                  shadow_screen[shadow_row][shadow_col] = item.char_code;
                  if (shadow_col == 6'(SCREEN_COLS - 1))
                     start_new_line(scrolled);
                  else
                     shadow_col = shadow_col + 6'd1;
               end
            endcase
         end
         REQ_READ: begin
            // reads off the screen return zero
            if (item.read_row < SCREEN_ROWS && item.read_col < SCREEN_COLS)
               outcome.cell_char = shadow_screen[item.read_row][item.read_col];
         end
         REQ_CLEAR: blank_shadow();
         default: ;
      endcase
      outcome.cursor_col = shadow_col;
      outcome.cursor_row = shadow_row;
      outcome.did_scroll = scrolled;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   function automatic probe_row_type probe_entry(
         input req_kind_type kind, input logic [7:0] code,
         input logic [4:0] row, input logic [5:0] col, input logic typed,
         input logic [7:0] cell_byte, input logic [5:0] ccol, input logic [4:0] crow);
      probe_row_type entry;
      entry.item.req_type      = kind;
      entry.item.char_code     = code;
      entry.item.read_row      = row;
      entry.item.read_col      = col;
      entry.typed              = typed;
      entry.answer.cell_char   = cell_byte;
      entry.answer.cursor_col  = ccol;
      entry.answer.cursor_row  = crow;
      entry.answer.did_scroll  = 1'b0;
      return entry;
   endfunction

   // Weighted random item: mostly text with newlines so that lines wrap and
   // the screen scrolls, reads half aimed at the cursor row, and a rare clear so
   // that the cursor gets to the bottom row between clears.
   function automatic req_type random_request();
      req_type     item;
      int unsigned pick;
      item.req_type  = REQ_PUT;
      item.char_code = 8'($urandom);
      item.read_row  = 5'($urandom);
      item.read_col  = 6'($urandom);
      pick = $urandom_range(0, 199);
      if (pick < 30) begin
         item.char_code = pick[0] ? CODE_CR : CODE_LF;
      end else if (pick < 40) begin
         item.char_code = CODE_BS;
      end else if (pick < 80) begin
         item.req_type = REQ_READ;
         item.read_row = pick[0] ? shadow_row : 5'($urandom_range(0, SCREEN_ROWS - 1));
         item.read_col = 6'($urandom_range(0, SCREEN_COLS - 1));
      end else if (pick < 85) begin
         // raw coordinates, mostly off the screen
         item.req_type = REQ_READ;
      end else if (pick < 89) begin
         item.req_type = REQ_NONE;
      end else if (pick == 89) begin
         item.req_type = REQ_CLEAR;
      end
      return item;
   endfunction

   // Offer one item at the falling edge and hold it until accepted. Valid is
   // left high on return so that a back-to-back item needs no second write.
   task automatic send_request(input req_type item);
      while (!calm_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Hold the sender off until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_rsps.size() != 0)
         @(negedge clock);
   endtask

   // Receiver: stall at random, except through the calm stretch.
   always @(negedge clock) begin
      rsp_ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   initial begin
      int i;
      blank_shadow();

      // Reads straight after reset, off-screen reads, an unused request type,
      // backspace in column 0, extreme and control codes, newline, clear.
      // Some ignored fields carry all ones.
      probe_table[0]  = probe_entry(REQ_READ,  8'hFF,     5'd0,  6'd0,  1'b1, CODE_SPACE, 6'd0, 5'd0);
      probe_table[1]  = probe_entry(REQ_READ,  8'h00,     5'd24, 6'd39, 1'b1, CODE_SPACE, 6'd0, 5'd0);
      probe_table[2]  = probe_entry(REQ_READ,  8'h00,     5'd25, 6'd0,  1'b1, 8'h00,      6'd0, 5'd0);
      probe_table[3]  = probe_entry(REQ_READ,  8'h00,     5'd0,  6'd40, 1'b1, 8'h00,      6'd0, 5'd0);
      probe_table[4]  = probe_entry(REQ_READ,  8'hAA,     5'd31, 6'd63, 1'b1, 8'h00,      6'd0, 5'd0);
      probe_table[5]  = probe_entry(REQ_NONE,  8'hFF,     5'd31, 6'd63, 1'b1, 8'h00,      6'd0, 5'd0);
      probe_table[6]  = probe_entry(REQ_PUT,   CODE_BS,   5'd31, 6'd63, 1'b1, 8'h00,      6'd0, 5'd0);
      probe_table[7]  = probe_entry(REQ_PUT,   8'h41,     5'd0,  6'd0,  1'b1, 8'h00,      6'd1, 5'd0);
      probe_table[8]  = probe_entry(REQ_PUT,   8'h00,     5'd31, 6'd63, 1'b1, 8'h00,      6'd2, 5'd0);
      probe_table[9]  = probe_entry(REQ_PUT,   8'hFF,     5'd0,  6'd0,  1'b1, 8'h00,      6'd3, 5'd0);
      probe_table[10] = probe_entry(REQ_PUT,   8'h07,     5'd0,  6'd0,  1'b1, 8'h00,      6'd4, 5'd0);
      probe_table[11] = probe_entry(REQ_READ,  8'h00,     5'd0,  6'd0,  1'b1, 8'h41,      6'd4, 5'd0);
      probe_table[12] = probe_entry(REQ_READ,  8'h00,     5'd0,  6'd2,  1'b1, 8'hFF,      6'd4, 5'd0);
      probe_table[13] = probe_entry(REQ_READ,  8'h00,     5'd0,  6'd1,  1'b1, 8'h00,      6'd4, 5'd0);
      probe_table[14] = probe_entry(REQ_PUT,   CODE_BS,   5'd0,  6'd0,  1'b1, 8'h00,      6'd3, 5'd0);
      probe_table[15] = probe_entry(REQ_READ,  8'h00,     5'd0,  6'd3,  1'b1, CODE_SPACE, 6'd3, 5'd0);
      probe_table[16] = probe_entry(REQ_PUT,   CODE_CR,   5'd0,  6'd0,  1'b1, 8'h00,      6'd0, 5'd1);
      probe_table[17] = probe_entry(REQ_PUT,   CODE_LF,   5'd0,  6'd0,  1'b1, 8'h00,      6'd0, 5'd2);
      probe_table[18] = probe_entry(REQ_PUT,   8'h5A,     5'd0,  6'd0,  1'b0, 8'h00,      6'd0, 5'd0);
      probe_table[19] = probe_entry(REQ_READ,  8'h00,     5'd2,  6'd0,  1'b0, 8'h00,      6'd0, 5'd0);
      probe_table[20] = probe_entry(REQ_CLEAR, 8'hFF,     5'd31, 6'd63, 1'b1, 8'h00,      6'd0, 5'd0);
      probe_table[21] = probe_entry(REQ_READ,  8'h00,     5'd2,  6'd0,  1'b1, CODE_SPACE, 6'd0, 5'd0);
      probe_table[22] = probe_entry(REQ_READ,  8'h00,     5'd0,  6'd0,  1'b1, CODE_SPACE, 6'd0, 5'd0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the probe table; typed-in results stand in for the prediction.
      for (i = 0; i < PROBE_COUNT; i++) begin
         typed_pending = probe_table[i].typed;
         typed_answer  = probe_table[i].answer;
         send_request(probe_table[i].item);
      end
      drain_results();
      typed_pending = 1'b0;

      // Random traffic; a calm stretch with no idling on either side, and a
      // full drain every so often.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         calm_stretch = (i >= CALM_FIRST && i <= CALM_LAST);
         if (i % DRAIN_INTERVAL == DRAIN_INTERVAL - 1)
            drain_results();
         send_request(random_request());
      end
      calm_stretch = 1'b0;
      drain_results();

      // Give a stray result time to show up before the verdict.
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Scoreboard: predict on acceptance, compare on each result, in order.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type oldest;
      if (!reset) begin
         if (req_valid && req_ready) begin
            advance_terminal(req_payload, predicted);
            expected_rsps.push_back(typed_pending ? typed_answer : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: result %h arrived with nothing outstanding",
                        $time, rsp_payload);
               mismatch_count++;
            end else begin
               oldest = expected_rsps.pop_front();
               if (rsp_payload.cell_char !== oldest.cell_char) begin
                  $display("%0t: cell_char expected %0d, got %0d",
                           $time, oldest.cell_char, rsp_payload.cell_char);
                  mismatch_count++;
               end
               if (rsp_payload.cursor_col !== oldest.cursor_col) begin
                  $display("%0t: cursor_col expected %0d, got %0d",
                           $time, oldest.cursor_col, rsp_payload.cursor_col);
                  mismatch_count++;
               end
               if (rsp_payload.cursor_row !== oldest.cursor_row) begin
                  $display("%0t: cursor_row expected %0d, got %0d",
                           $time, oldest.cursor_row, rsp_payload.cursor_row);
                  mismatch_count++;
               end
               if (rsp_payload.did_scroll !== oldest.did_scroll) begin
                  $display("%0t: did_scroll expected %0d, got %0d",
                           $time, oldest.did_scroll, rsp_payload.did_scroll);
                  mismatch_count++;
               end
            end
         end
         // count cycles in which neither channel moves an item
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: drop the run if nothing moves for too long.
   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("%0t: watchdog, no item moved for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, expected_rsps.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### files.f
hw/rtl/ttcs_pkg.sv
hw/rtl/ttcs_ram.sv
hw/rtl/ttcs_ctrl.sv
hw/rtl/ttcs_dp.sv
hw/rtl/text_terminal_cursor_scroll.sv
hw/rtl/ttcs_chk.sv
tb/tb.sv
